// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is low.
`define XM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is low.
`define XM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/xm1k_pkg.sv -----
package xm1k_pkg;

  // link control characters
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_POLL = 8'h43;

  // command codes
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  // timer_restart codes
  localparam logic [1:0] TMR_NONE   = 2'd0;
  localparam logic [1:0] TMR_POLL   = 2'd1;
  localparam logic [1:0] TMR_PACKET = 2'd2;

  // status codes
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WORKING = 3'd1;
  localparam logic [2:0] ST_TRAILER = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  localparam logic [7:0] MAX_RETRIES_RST = 8'd10;
  localparam logic [3:0] TRAILER_BYTES   = 4'd8;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_CONNECT = 6'b000010,
    PH_RECV    = 6'b000100,
    PH_TRAILER = 6'b001000,
    PH_DONE    = 6'b010000,
    PH_FAILED  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [1:0]  timer_restart;
    logic        data_valid;
    logic [9:0]  data_index;
    logic [7:0]  data_byte;
    logic        block_good;
    logic [15:0] frame_number;
    logic [2:0]  status;
    logic [31:0] image_size;
    logic [31:0] image_crc;
  } out_rsp_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] status_of(input phase_e ph);
    logic [2:0] s;
    case (ph)
      PH_IDLE:    s = ST_IDLE;
      PH_CONNECT: s = ST_WORKING;
      PH_RECV:    s = ST_WORKING;
      PH_TRAILER: s = ST_TRAILER;
      PH_DONE:    s = ST_DONE;
      default:    s = ST_FAILED;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/xmodem1k_receiver_unit.sv -----
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------
// in       | input     | in_valid_i/in_stall_o   | in_req_i  (in_req_t)
// out      | output    | out_valid_o/out_stall_i | out_rsp_o (out_rsp_t)
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (max_retries)
//
// One request per cycle while in_stall_o is low; every accepted request yields one
// result, in the cycle after it is taken. All state update and the byte-wide CRC
// step sit between the input port and the result register, so throughput is set by that single register stage.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset is asynchronous; requests are accepted as soon as it is released.
module xmodem1k_receiver_unit
  import xm1k_pkg::*;
#(
  parameter int PAYLOAD_LEN = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int PosW = $clog2(PAYLOAD_LEN + 5);
  localparam logic [PosW-1:0] PosCrcHi = PosW'(PAYLOAD_LEN + 3);
  localparam logic [PosW-1:0] PosCrcLo = PosW'(PAYLOAD_LEN + 4);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     frame_q, frame_d;
  logic [15:0]     rcrc_q, rcrc_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      retries_q, retries_d;
  logic [3:0]      tcnt_q, tcnt_d;
  logic [63:0]     tshift_q, tshift_d;
  logic [7:0]      max_retries_q;
  logic            out_valid_q;
  out_rsp_t        out_rsp_q, rsp_d;
  logic            in_acc;
  logic [PosW-1:0] pos_m3;
  logic [7:0]      b;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;
  assign b           = in_req_i.rx_byte;
  assign pos_m3      = pos_q - PosW'(3);

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    frame_d   = frame_q;
    rcrc_d    = rcrc_q;
    crc_d     = crc_q;
    retries_d = retries_q;
    tcnt_d    = tcnt_q;
    tshift_d  = tshift_q;
    rsp_d     = '0;

    case (in_req_i.command)
      CMD_START: begin
        rsp_d.tx_valid      = 1'b1;
        rsp_d.tx_byte       = CH_POLL;
        rsp_d.timer_restart = TMR_POLL;
        retries_d           = max_retries_q;
        phase_d             = PH_CONNECT;
        pos_d               = '0;
        crc_d               = '0;
        tcnt_d              = '0;
        tshift_d            = '0;
      end
      CMD_BYTE: begin
        case (phase_q)
          PH_CONNECT: begin
            if (b == CH_SOH) begin
              pos_d               = PosW'(1);
              crc_d               = '0;
              rsp_d.timer_restart = TMR_PACKET;
              phase_d             = PH_RECV;
            end
          end
          PH_RECV: begin
            if (pos_q == '0) begin
              // between blocks: next SOH or end of transfer
              if (b == CH_SOH) begin
                pos_d               = PosW'(1);
                crc_d               = '0;
                rsp_d.timer_restart = TMR_PACKET;
              end else if (b == CH_EOT) begin
                phase_d  = PH_TRAILER;
                tcnt_d   = '0;
                tshift_d = '0;
              end
            end else if (pos_q == PosW'(1)) begin
              frame_d = {8'h00, b};
              pos_d   = PosW'(2);
            end else if (pos_q == PosW'(2)) begin
              frame_d = {frame_q[7:0], b};
              pos_d   = PosW'(3);
            end else if (pos_q == PosCrcHi) begin
              rcrc_d = {8'h00, b};
              pos_d  = pos_q + PosW'(1);
            end else if (pos_q >= PosCrcLo) begin
              rcrc_d         = {rcrc_q[7:0], b};
              rsp_d.tx_valid = 1'b1;
              if (rcrc_d == crc_q) begin
                rsp_d.tx_byte    = CH_ACK;
                rsp_d.block_good = 1'b1;
              end else begin
                rsp_d.tx_byte = CH_NAK;
              end
              pos_d = '0;
            end else begin
              rsp_d.data_valid = 1'b1;
              rsp_d.data_index = 10'(pos_m3);
              rsp_d.data_byte  = b;
              crc_d            = crc16_byte(crc_q, b);
              pos_d            = pos_q + PosW'(1);
            end
          end
          PH_TRAILER: begin
            tshift_d = {tshift_q[55:0], b};
            tcnt_d   = tcnt_q + 4'd1;
            if (tcnt_d >= TRAILER_BYTES) begin
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      CMD_TIMEOUT: begin
        if (phase_q == PH_CONNECT || phase_q == PH_RECV) begin
          if (retries_q != '0) begin
            retries_d           = retries_q - 8'd1;
            rsp_d.tx_valid      = 1'b1;
            rsp_d.timer_restart = TMR_POLL;
            if (phase_q == PH_CONNECT) begin
              rsp_d.tx_byte = CH_POLL;
            end else begin
              rsp_d.tx_byte = CH_NAK;
              pos_d         = '0;
            end
          end else begin
            phase_d = PH_FAILED;
          end
        end
      end
      default: ;
    endcase

    rsp_d.frame_number = frame_d;
    rsp_d.status       = status_of(phase_d);
    if (phase_d == PH_DONE) begin
      rsp_d.image_size = tshift_d[63:32];
      rsp_d.image_crc  = tshift_d[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      pos_q         <= '0;
      frame_q       <= '0;
      rcrc_q        <= '0;
      crc_q         <= '0;
      retries_q     <= '0;
      tcnt_q        <= '0;
      tshift_q      <= '0;
      max_retries_q <= MAX_RETRIES_RST;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_retries_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        frame_q   <= frame_d;
        rcrc_q    <= rcrc_d;
        crc_q     <= crc_d;
        retries_q <= retries_d;
        tcnt_q    <= tcnt_d;
        tshift_q  <= tshift_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_rsp_q <= rsp_d;
    end
  end

endmodule

// ----- rtl/core/xm1k_checker.sv -----
`include "assert_macros.svh"

module xm1k_checker
  import xm1k_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_rsp_t   out_rsp_o
);

  logic held, show_data, data_ctl, show_good, ack_out, not_done, trl_zero;

  assign held      = out_valid_o & out_stall_i;
  assign show_data = out_valid_o & out_rsp_o.data_valid;
  assign data_ctl  = out_rsp_o.tx_valid | out_rsp_o.block_good;
  assign show_good = out_valid_o & out_rsp_o.block_good;
  assign ack_out   = out_rsp_o.tx_valid & (out_rsp_o.tx_byte == CH_ACK);
  assign not_done  = out_valid_o & (out_rsp_o.status != ST_DONE);
  assign trl_zero  = (out_rsp_o.image_size == '0) & (out_rsp_o.image_crc == '0);

  // a held result stays put until taken
  `XM_ASSERT(a_out_hold, clk_i, rst_ni, held |=> out_valid_o && $stable(out_rsp_o), "stall hold")

  `XM_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

  // a payload byte never goes out together with a control byte
  `XM_ASSERT(a_data_no_tx, clk_i, rst_ni, show_data |-> !data_ctl, "payload byte with control action")

  `XM_ASSERT(a_good_ack, clk_i, rst_ni, show_good |-> ack_out, "block commit without ACK")

  `XM_ASSERT(a_image_done, clk_i, rst_ni, not_done |-> trl_zero, "trailer values before done")

endmodule

bind xmodem1k_receiver_unit xm1k_checker u_xm1k_checker (.*);

// ----- sim/xmodem1k_receiver_unit_tb.sv -----
import xm1k_pkg::*;

// Tracks the receiver's protocol state and holds the results it should produce.
class xfer_scoreboard #(int PLEN = 1024);
  phase_e      phase;
  logic [10:0] pos;
  logic [15:0] frame;
  logic [15:0] crc_rx;
  logic [15:0] crc_run;
  logic [7:0]  retries_max;
  logic [7:0]  retries_left;
  logic [3:0]  trl_cnt;
  logic [63:0] trl_shift;
  out_rsp_t    expected_q[$];
  int          errors;
  int          results_seen;

  function new();
    retries_max  = MAX_RETRIES_RST;
    phase        = PH_IDLE;
    pos          = '0;
    frame        = '0;
    crc_rx       = '0;
    crc_run      = '0;
    retries_left = '0;
    trl_cnt      = '0;
    trl_shift    = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  // CRC-16 with poly 0x1021, one bit of the byte at a time, MSB first
  static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ 16'h1021;
    end
    return c;
  endfunction

  function void set_retries(logic [7:0] v);
    retries_max = v;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_request(in_req_t r);
    out_rsp_t    e;
    logic [7:0]  b;
    logic [10:0] idx;
    e = '0;
    b = r.rx_byte;
    case (r.command)
      CMD_START: begin
        e.tx_valid      = 1'b1;
        e.tx_byte       = CH_POLL;
        e.timer_restart = TMR_POLL;
        retries_left    = retries_max;
        phase           = PH_CONNECT;
        pos             = '0;
        crc_run         = '0;
        trl_cnt         = '0;
        trl_shift       = '0;
      end
      CMD_BYTE: begin
        case (phase)
          PH_CONNECT: begin
            if (b == CH_SOH) begin
              pos = 11'd1;
              crc_run = '0;
              e.timer_restart = TMR_PACKET;
              phase = PH_RECV;
            end
          end
          PH_RECV: begin
            if (pos == 11'd0) begin
              if (b == CH_SOH) begin
                pos = 11'd1;
                crc_run = '0;
                e.timer_restart = TMR_PACKET;
              end else if (b == CH_EOT) begin
                phase = PH_TRAILER;
                trl_cnt = '0;
                trl_shift = '0;
              end
            end else if (pos == 11'd1) begin
              frame = {8'h00, b};
              pos = 11'd2;
            end else if (pos == 11'd2) begin
              frame = {frame[7:0], b};
              pos = 11'd3;
            end else if (pos == 11'(PLEN + 3)) begin
              crc_rx = {8'h00, b};
              pos = pos + 11'd1;
            end else if (pos >= 11'(PLEN + 4)) begin
              crc_rx = {crc_rx[7:0], b};
              e.tx_valid = 1'b1;
              if (crc_rx == crc_run) begin
                e.tx_byte = CH_ACK;
                e.block_good = 1'b1;
              end else begin
                e.tx_byte = CH_NAK;
              end
              pos = '0;
            end else begin
              idx = pos - 11'd3;
              e.data_valid = 1'b1;
              e.data_index = idx[9:0];
              e.data_byte = b;
              crc_run = crc_next(crc_run, b);
              pos = pos + 11'd1;
            end
          end
          PH_TRAILER: begin
            trl_shift = {trl_shift[55:0], b};
            trl_cnt = trl_cnt + 4'd1;
            if (trl_cnt >= TRAILER_BYTES) phase = PH_DONE;
          end
          default: ;
        endcase
      end
      CMD_TIMEOUT: begin
        if (phase == PH_CONNECT || phase == PH_RECV) begin
          if (retries_left != 8'd0) begin
            retries_left = retries_left - 8'd1;
            e.tx_valid = 1'b1;
            e.timer_restart = TMR_POLL;
            if (phase == PH_CONNECT) begin
              e.tx_byte = CH_POLL;
            end else begin
              e.tx_byte = CH_NAK;
              pos = '0;
            end
          end else begin
            phase = PH_FAILED;
          end
        end
      end
      default: ;
    endcase

    e.frame_number = frame;
    case (phase)
      PH_IDLE:                e.status = ST_IDLE;
      PH_CONNECT, PH_RECV:    e.status = ST_WORKING;
      PH_TRAILER:             e.status = ST_TRAILER;
      PH_DONE:                e.status = ST_DONE;
      default:                e.status = ST_FAILED;
    endcase
    if (phase == PH_DONE) begin
      e.image_size = trl_shift[63:32];
      e.image_crc  = trl_shift[31:0];
    end
    expected_q.push_back(e);
  endfunction

  task report(string msg);
    errors++;
    $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task check_result(out_rsp_t got);
    out_rsp_t e;
    if (expected_q.size() == 0) begin
      report("result with no request outstanding");
      return;
    end
    e = expected_q.pop_front();
    compare_field("tx_valid", 32'(got.tx_valid), 32'(e.tx_valid));
    compare_field("tx_byte", 32'(got.tx_byte), 32'(e.tx_byte));
    compare_field("timer_restart", 32'(got.timer_restart), 32'(e.timer_restart));
    compare_field("data_valid", 32'(got.data_valid), 32'(e.data_valid));
    compare_field("data_index", 32'(got.data_index), 32'(e.data_index));
    compare_field("data_byte", 32'(got.data_byte), 32'(e.data_byte));
    compare_field("block_good", 32'(got.block_good), 32'(e.block_good));
    compare_field("frame_number", 32'(got.frame_number), 32'(e.frame_number));
    compare_field("status", 32'(got.status), 32'(e.status));
    compare_field("image_size", got.image_size, e.image_size);
    compare_field("image_crc", got.image_crc, e.image_crc);
    results_seen++;
  endtask
endclass

module xmodem1k_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_LEN = 1024;
  localparam int IDLE_LIMIT  = 2000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int BLK_GOOD    = 0;
  localparam int BLK_BAD     = 1;
  localparam int BLK_CUT     = 2;
  localparam int BLK_CRC_CUT = 3;

  localparam int STALL_NONE   = 0;
  localparam int STALL_SPARSE = 1;
  localparam int STALL_RUNS   = 2;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_req_t    in_req_i    = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_rsp_t   out_rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = '0;

  xfer_scoreboard #(PAYLOAD_LEN) sb;

  int         burst_left  = 0;
  int         gap_len     = 0;
  int         sent_items  = 0;
  int         full_owed   = 2;
  int         idle_cycles = 0;
  int         stall_mode  = STALL_NONE;
  int         stall_seg   = 0;
  int         stall_run   = 0;
  logic [7:0] retries_now = MAX_RETRIES_RST;

  logic [7:0] trailer_pat [8] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};

  xmodem1k_receiver_unit #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver back-pressure: quiet stretches, scattered stalls, stall runs
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_seg == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
        stall_seg = $urandom_range(20, 300);
      end
      stall_seg--;
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_SPARSE: out_stall_i <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run == 0 && $urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 8);
          out_stall_i <= (stall_run != 0);
          if (stall_run != 0) stall_run--;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_retries(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // one request; the sender may pause between bursts of random length
  task automatic send(input logic [1:0] cmd, input logic [7:0] b);
    if (burst_left == 0) begin
      if (gap_len > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{command: cmd, rx_byte: b};
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    sent_items++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_retries(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    retries_now = v;
  endtask

  task automatic noise();
    case ($urandom_range(0, 3))
      0: send(CMD_TIMEOUT, 8'($urandom));
      1: send(CMD_UNUSED, 8'($urandom));
      default: send(CMD_BYTE, 8'($urandom));
    endcase
  endtask

  task automatic send_block(input int kind);
    logic [15:0] crc;
    logic [7:0]  b;
    int          hdr;
    int          n;
    crc = '0;
    send(CMD_BYTE, CH_SOH);
    hdr = (kind == BLK_CUT && $urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : 2;
    repeat (hdr) send(CMD_BYTE, 8'($urandom));
    if (hdr == 2) begin
      n = (kind == BLK_CUT) ? $urandom_range(0, 48) : PAYLOAD_LEN;
      repeat (n) begin
        b = 8'($urandom);
        crc = sb.crc_next(crc, b);
        send(CMD_BYTE, b);
      end
      if (kind == BLK_GOOD || kind == BLK_BAD) begin
        if (kind == BLK_BAD) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send(CMD_BYTE, crc[15:8]);
        send(CMD_BYTE, crc[7:0]);
      end else if (kind == BLK_CRC_CUT && $urandom_range(0, 1) == 1) begin
        send(CMD_BYTE, crc[15:8]);
      end
    end
    // cut blocks end with a timeout or a fresh start
    if (kind == BLK_CUT || kind == BLK_CRC_CUT) begin
      send(($urandom_range(0, 3) == 0) ? CMD_START : CMD_TIMEOUT, 8'($urandom));
    end
  endtask

  task automatic run_session();
    int kind;
    send(CMD_START, 8'($urandom));
    repeat ($urandom_range(0, 2)) noise();
    repeat ($urandom_range(0, 4)) begin
      if (full_owed > 0) begin
        kind = (full_owed == 2) ? BLK_GOOD : BLK_BAD;
        full_owed--;
      end else if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0: kind = BLK_GOOD;
          1: kind = BLK_BAD;
          default: kind = BLK_CRC_CUT;
        endcase
      end else begin
        kind = BLK_CUT;
      end
      send_block(kind);
      if ($urandom_range(0, 5) == 0) noise();
    end
    case ($urandom_range(0, 7))
      0: begin
        // spend timeouts on the retry budget, down to failure when it is 12 or less
        repeat ((retries_now > 12) ? 3 : retries_now + 1) send(CMD_TIMEOUT, 8'($urandom));
        noise();
      end
      1: ;
      default: begin
        send(CMD_BYTE, CH_EOT);
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 8)
          send(CMD_BYTE, 8'($urandom));
        repeat ($urandom_range(0, 2)) noise();
      end
    endcase
  endtask

  initial begin
    int phase_start;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: retry budget at its reset value
    send(CMD_BYTE, 8'hFF);
    send(CMD_TIMEOUT, 8'h00);
    send(CMD_UNUSED, 8'hAA);
    send(CMD_START, 8'h55);
    send(CMD_BYTE, CH_EOT);     // not SOH, ignored while connecting
    send(CMD_TIMEOUT, 8'h00);   // re-poll
    send(CMD_BYTE, CH_SOH);
    send(CMD_BYTE, 8'h00);
    send(CMD_BYTE, 8'hFF);
    send(CMD_BYTE, 8'hFF);
    send(CMD_BYTE, 8'h00);
    send(CMD_TIMEOUT, 8'hFF);   // NAK mid-block
    send(CMD_BYTE, 8'h55);      // junk between blocks
    send(CMD_BYTE, CH_EOT);
    send(CMD_TIMEOUT, 8'h00);   // no effect in trailer
    foreach (trailer_pat[i]) send(CMD_BYTE, trailer_pat[i]);
    send(CMD_BYTE, CH_SOH);
    send(CMD_TIMEOUT, 8'h00);
    send(CMD_START, 8'h00);
    wait_idle();
    write_retries(8'd0);
    send(CMD_START, 8'h00);
    send(CMD_TIMEOUT, 8'h00);   // no budget left: fails without sending
    send(CMD_BYTE, CH_SOH);
    send(CMD_TIMEOUT, 8'h00);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: write_retries(8'd255);
        1: write_retries(8'd1);
        2: write_retries(8'd0);
        3: write_retries(8'($urandom));
        4: write_retries(8'd4);
        default: write_retries(8'd2);
      endcase
      phase_start = sent_items;
      while (sent_items - phase_start < 170) run_session();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
